FILE: hdl/rope_pkg.sv
package rope_pkg;

	localparam int DATA_WIDTH       = 32;
	localparam int ANGLE_ITERATIONS = 24;
	localparam int LOG_FRAC_BITS    = 20;

	localparam logic [31:0] PI_HALF_Q31     = 32'd3373259426;
	localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
	localparam logic [17:0] SCALE_ONE       = 18'h10000;
	localparam logic [17:0] SCALE_MAX       = 18'h3FFFF;

	// Top quotient bit index of the quadrant reduction and of the scale division.
	localparam int RDC_TOP = 18;
	localparam int DIV_TOP = 18;

	localparam int STAGES = 2 + (RDC_TOP + 1) + ANGLE_ITERATIONS + 1 + LOG_FRAC_BITS
		+ (DIV_TOP + 1) + 4;

	localparam logic signed [37:0] SAT_HI = 38'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [37:0] SAT_LO = -SAT_HI - 38'sd1;

	typedef enum logic [3:0] {
		OP_POS, OP_MUL, OP_RDC, OP_CRD, OP_LNM, OP_LSQ, OP_DVS,
		OP_PRD, OP_SUM, OP_SCL, OP_SAT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
	} ctl_t;

	typedef struct packed {
		logic [15:0]        seq;
		logic [15:0]        step;
		logic [15:0]        off;
		logic [31:0]        freq;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               last;
		logic               rot;
		logic [15:0]        thr;
		logic               act;
		logic [17:0]        pos;
		logic [49:0]        rem;
		logic [1:0]         quad;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [34:0] z;
		logic [31:0]        mp;
		logic [31:0]        mt;
		logic [24:0]        lp;
		logic [24:0]        lt;
		logic [43:0]        drem;
		logic [17:0]        q;
		logic               ovf;
		logic signed [65:0] p1;
		logic signed [65:0] p2;
		logic signed [65:0] p3;
		logic signed [65:0] p4;
		logic signed [37:0] r1;
		logic signed [37:0] r2;
		logic               sat;
	} item_t;

	// Arctangent of 2^-i in Q31 radians, rounded.
	function automatic logic signed [34:0] atan_q31(input logic [4:0] i);
		logic signed [34:0] v;
		case (i)
			5'd0:    v = 35'sd1686629713;
			5'd1:    v = 35'sd995675659;
			5'd2:    v = 35'sd526087673;
			5'd3:    v = 35'sd267050317;
			5'd4:    v = 35'sd134043374;
			5'd5:    v = 35'sd67087031;
			5'd6:    v = 35'sd33551702;
			5'd7:    v = 35'sd16776875;
			5'd8:    v = 35'sd8388565;
			5'd9:    v = 35'sd4194299;
			5'd10:   v = 35'sd2097151;
			default: v = 35'sd1 <<< (5'd31 - i);
		endcase
		return v;
	endfunction

	// Operation performed by each cell along the chain.
	function automatic ctl_t stage_ctl(input int k);
		ctl_t c;
		int   r;
		r = k;
		c.op  = OP_SAT;
		c.idx = '0;
		if (r == 0) begin
			c.op = OP_POS;
		end else if (r == 1) begin
			c.op = OP_MUL;
		end else begin
			r = r - 2;
			if (r <= RDC_TOP) begin
				c.op  = OP_RDC;
				c.idx = 5'(RDC_TOP - r);
			end else begin
				r = r - (RDC_TOP + 1);
				if (r < ANGLE_ITERATIONS) begin
					c.op  = OP_CRD;
					c.idx = 5'(r);
				end else begin
					r = r - ANGLE_ITERATIONS;
					if (r == 0) begin
						c.op = OP_LNM;
					end else if (r <= LOG_FRAC_BITS) begin
						c.op = OP_LSQ;
					end else begin
						r = r - (LOG_FRAC_BITS + 1);
						if (r <= DIV_TOP) begin
							c.op  = OP_DVS;
							c.idx = 5'(DIV_TOP - r);
						end else begin
							r = r - (DIV_TOP + 1);
							case (r)
								0:       c.op = OP_PRD;
								1:       c.op = OP_SUM;
								2:       c.op = OP_SCL;
								default: c.op = OP_SAT;
							endcase
						end
					end
				end
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/rope_cell.sv
module rope_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  rope_pkg::ctl_t      ctl,
	input  logic                in_valid,
	input  rope_pkg::item_t     d,
	output logic                out_valid,
	output rope_pkg::item_t     q
);

	rope_pkg::item_t    nxt;
	logic [49:0]        dsh;
	logic signed [34:0] zc;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [34:0] at;
	logic [4:0]         pm;
	logic [4:0]         tm;
	logic [63:0]        sqp;
	logic [63:0]        sqt;
	logic [43:0]        r0;
	logic [43:0]        dv;
	logic signed [33:0] c;
	logic signed [33:0] s;
	logic signed [65:0] t1;
	logic signed [65:0] t2;
	logic [17:0]        sc18;
	logic signed [19:0] sc;
	logic signed [57:0] m1;
	logic signed [57:0] m2;

	always_comb begin
		nxt  = d;
		dsh  = '0;
		zc   = '0;
		dx   = '0;
		dy   = '0;
		at   = '0;
		pm   = '0;
		tm   = '0;
		sqp  = '0;
		sqt  = '0;
		r0   = '0;
		dv   = '0;
		c    = '0;
		s    = '0;
		t1   = '0;
		t2   = '0;
		sc18 = '0;
		sc   = '0;
		m1   = '0;
		m2   = '0;
		case (ctl.op)
			rope_pkg::OP_POS: begin
				nxt.pos = 18'(d.seq) + 18'(d.step) + 18'(d.off);
				nxt.act = d.rot && (d.thr != 16'd0) && (nxt.pos > 18'(d.thr));
				nxt.x   = rope_pkg::CORDIC_GAIN_Q30;
				nxt.y   = '0;
			end
			rope_pkg::OP_MUL: begin
				nxt.rem  = 50'(d.freq) * 50'(d.pos);
				nxt.quad = '0;
			end
			rope_pkg::OP_RDC: begin
				dsh = 50'(rope_pkg::PI_HALF_Q31) << ctl.idx;
				if (d.rem >= dsh) begin
					nxt.rem = d.rem - dsh;
					if (ctl.idx == 5'd0)
						nxt.quad[0] = 1'b1;
					if (ctl.idx == 5'd1)
						nxt.quad[1] = 1'b1;
				end
			end
			rope_pkg::OP_CRD: begin
				// The first iteration takes the reduced angle as its residual.
				zc = (ctl.idx == 5'd0) ? $signed({3'b000, d.rem[31:0]}) : d.z;
				dx = d.y >>> ctl.idx;
				dy = d.x >>> ctl.idx;
				at = rope_pkg::atan_q31(ctl.idx);
				if (zc >= 0) begin
					nxt.x = d.x - dx;
					nxt.y = d.y + dy;
					nxt.z = zc - at;
				end else begin
					nxt.x = d.x + dx;
					nxt.y = d.y - dy;
					nxt.z = zc + at;
				end
			end
			rope_pkg::OP_LNM: begin
				for (int j = 0; j < 18; j++)
					if (d.pos[j])
						pm = 5'(j);
				for (int j = 0; j < 16; j++)
					if (d.thr[j])
						tm = 5'(j);
				nxt.mp = 32'(d.pos) << (5'd31 - pm);
				nxt.mt = 32'(d.thr) << (5'd31 - tm);
				nxt.lp = {pm, 20'd0};
				nxt.lt = {tm, 20'd0};
			end
			rope_pkg::OP_LSQ: begin
				sqp = 64'(d.mp) * 64'(d.mp);
				sqt = 64'(d.mt) * 64'(d.mt);
				nxt.lp[19:0] = {d.lp[18:0], sqp[63]};
				nxt.lt[19:0] = {d.lt[18:0], sqt[63]};
				nxt.mp = sqp[63] ? sqp[63:32] : sqp[62:31];
				nxt.mt = sqt[63] ? sqt[63:32] : sqt[62:31];
			end
			rope_pkg::OP_DVS: begin
				if (ctl.idx == 5'(rope_pkg::DIV_TOP)) begin
					// A quotient that would not fit in Q2.16 is clipped; a zero
					// divisor always lands here.
					r0 = 44'(d.lp) << 16;
					nxt.drem = r0;
					nxt.ovf  = r0 >= (44'(d.lt) << rope_pkg::DIV_TOP);
					nxt.q    = '0;
				end else begin
					dv = 44'(d.lt) << ctl.idx;
					if (d.drem >= dv) begin
						nxt.drem = d.drem - dv;
						nxt.q    = d.q | (18'd1 << ctl.idx);
					end
				end
			end
			rope_pkg::OP_PRD: begin
				case (d.quad)
					2'd0: begin c = d.x;  s = d.y;  end
					2'd1: begin c = -d.y; s = d.x;  end
					2'd2: begin c = -d.x; s = -d.y; end
					default: begin c = d.y; s = -d.x; end
				endcase
				nxt.p1 = 66'(d.a) * 66'(c);
				nxt.p2 = 66'(d.b) * 66'(s);
				nxt.p3 = 66'(d.b) * 66'(c);
				nxt.p4 = 66'(d.a) * 66'(s);
			end
			rope_pkg::OP_SUM: begin
				t1 = d.p1 - d.p2 + (66'sd1 <<< 29);
				t2 = d.p3 + d.p4 + (66'sd1 <<< 29);
				nxt.r1 = 38'(t1 >>> 30);
				nxt.r2 = 38'(t2 >>> 30);
			end
			rope_pkg::OP_SCL: begin
				sc18 = d.act ? (d.ovf ? rope_pkg::SCALE_MAX : d.q) : rope_pkg::SCALE_ONE;
				sc = $signed({2'b00, sc18});
				m1 = 58'(d.r1) * 58'(sc) + (58'sd1 <<< 15);
				m2 = 58'(d.r2) * 58'(sc) + (58'sd1 <<< 15);
				nxt.r1 = 38'(m1 >>> 16);
				nxt.r2 = 38'(m2 >>> 16);
			end
			rope_pkg::OP_SAT: begin
				nxt.sat = 1'b0;
				if (!d.rot) begin
					nxt.r1 = 38'(d.a);
					nxt.r2 = 38'(d.b);
				end else begin
					if (d.r1 > rope_pkg::SAT_HI) begin
						nxt.r1 = rope_pkg::SAT_HI;
						nxt.sat = 1'b1;
					end else if (d.r1 < rope_pkg::SAT_LO) begin
						nxt.r1 = rope_pkg::SAT_LO;
						nxt.sat = 1'b1;
					end
					if (d.r2 > rope_pkg::SAT_HI) begin
						nxt.r2 = rope_pkg::SAT_HI;
						nxt.sat = 1'b1;
					end else if (d.r2 < rope_pkg::SAT_LO) begin
						nxt.r2 = rope_pkg::SAT_LO;
						nxt.sat = 1'b1;
					end
				end
			end
			default: nxt = d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			q <= nxt;
	end

endmodule

FILE: hdl/rotary_embedding_half_split_logn_top.sv
// Pipeline: an accepted input transaction passes through every cell of the chain in turn
// on its way to its result.
// Throughput: one transaction per cycle; the whole chain advances together and
// stops only while a finished result is held back by result_stall.
// Reset: arst_n clears every valid flag and sets the threshold to 0 and rotation on;
// payload registers are not reset.
module rotary_embedding_half_split_logn_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [15:0]        sequence_position,
	input  logic [15:0]        step_base,
	input  logic [15:0]        extra_offset,
	input  logic [31:0]        inverse_frequency,
	input  logic signed [31:0] first_value,
	input  logic signed [31:0] second_value,
	input  logic               last_pair,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] first_result,
	output logic signed [31:0] second_result,
	output logic               result_last,
	output logic               saturated
);

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_ROTATE    = 2'd1;

	logic [15:0]     thr_q;
	logic            rot_q;
	logic            adv;
	rope_pkg::item_t head;
	rope_pkg::item_t chain [rope_pkg::STAGES];
	logic            vld   [rope_pkg::STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd0;
			rot_q <= 1'b1;
		end else if (cfg_write) begin
			if (cfg_index == REG_THRESHOLD)
				thr_q <= cfg_data;
			else if (cfg_index == REG_ROTATE)
				rot_q <= cfg_data[0];
		end
	end

	assign adv        = !(vld[rope_pkg::STAGES-1] && result_stall);
	assign item_stall = !adv;

	always_comb begin
		head      = '0;
		head.seq  = sequence_position;
		head.step = step_base;
		head.off  = extra_offset;
		head.freq = inverse_frequency;
		head.a    = first_value;
		head.b    = second_value;
		head.last = last_pair;
		head.rot  = rot_q;
		head.thr  = thr_q;
	end

	for (genvar k = 0; k < rope_pkg::STAGES; k++) begin : g_cell
		if (k == 0) begin : g_first
			rope_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.ctl       (rope_pkg::stage_ctl(k)),
				.in_valid  (item_valid),
				.d         (head),
				.out_valid (vld[k]),
				.q         (chain[k])
			);
		end else begin : g_next
			rope_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.ctl       (rope_pkg::stage_ctl(k)),
				.in_valid  (vld[k-1]),
				.d         (chain[k-1]),
				.out_valid (vld[k]),
				.q         (chain[k])
			);
		end
	end

	assign result_valid  = vld[rope_pkg::STAGES-1];
	assign first_result  = chain[rope_pkg::STAGES-1].r1[31:0];
	assign second_result = chain[rope_pkg::STAGES-1].r2[31:0];
	assign result_last   = chain[rope_pkg::STAGES-1].last;
	assign saturated     = chain[rope_pkg::STAGES-1].sat;

endmodule

FILE: hdl/rope_chk.sv
module rope_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] first_result,
	input logic [31:0] second_result,
	input logic        saturated
);

	// The input side is held back only by a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a held result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(first_result)
			&& $stable(second_result)))
		else $error("held result changed");

	// A clipped transaction shows a bound on at least one of its results.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |-> (first_result == 32'h7FFFFFFF
			|| first_result == 32'h80000000 || second_result == 32'h7FFFFFFF
			|| second_result == 32'h80000000))
		else $error("saturated flag without a clipped result");

	// Reset clears the valid flags, so a result is never valid following a sampled reset.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

endmodule

bind rotary_embedding_half_split_logn_top rope_chk u_rope_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.first_result  (first_result),
	.second_result (second_result),
	.saturated     (saturated)
);

FILE: sim/rotary_embedding_half_split_logn_top_tb.sv
`timescale 1ns / 1ps

typedef struct {
	logic [31:0] first;
	logic [31:0] second;
	logic        last;
	logic        sat;
} rotated_pair_t;

class rotary_scoreboard;
	longint        atan_tab[32];
	logic [15:0]   threshold;
	logic          rotate;
	rotated_pair_t pending[$];
	int            errors;

	function new();
		longint unsigned sum, term;
		int              e;
		atan_tab[0] = 64'd1686629713;
		for (int i = 1; i < 32; i++) begin
			sum = 0;
			for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
				e = 62 - (2 * k + 1) * i;
				term = (64'd1 << e) / (2 * k + 1);
				if (k & 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			atan_tab[i] = longint'((sum + (64'd1 << 30)) >> 31);
		end
		threshold = 16'd0;
		rotate = 1'b1;
		errors = 0;
	endfunction

	function longint unsigned log2_q20(longint unsigned v);
		int              msb;
		longint unsigned m, frac;
		msb = 31;
		frac = 0;
		while (msb > 0 && !v[msb])
			msb--;
		m = v << (31 - msb);
		for (int k = 0; k < rope_pkg::LOG_FRAC_BITS; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(msb) << rope_pkg::LOG_FRAC_BITS) | frac;
	endfunction

	function longint round_q(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function longint clip(longint v, ref logic hit);
		longint hi;
		hi = (longint'(1) <<< (rope_pkg::DATA_WIDTH - 1)) - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			hit = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function void note(logic [15:0] seq, logic [15:0] step, logic [15:0] off,
			logic [31:0] freq, logic signed [31:0] fv, logic signed [31:0] sv, logic last);
		rotated_pair_t   r;
		longint unsigned pos, angle, lp, lt, q, quad;
		longint          a, b, x, y, z, c, s, dx, dy, scale, r1, r2;
		logic            hit;
		pos = longint'(seq) + longint'(step) + longint'(off);
		a = longint'(fv);
		b = longint'(sv);
		hit = 1'b0;
		scale = 64'h10000;
		r.last = last;
		if (!rotate) begin
			r.first = fv;
			r.second = sv;
			r.sat = 1'b0;
			pending.push_back(r);
			return;
		end
		if (threshold != 0 && pos > threshold) begin
			lp = log2_q20(pos);
			lt = log2_q20(64'(threshold));
			if (lt == 0)
				scale = 64'h3FFFF;
			else begin
				q = (lp << 16) / lt;
				scale = (q > 64'h3FFFF) ? 64'h3FFFF : longint'(q);
			end
		end
		angle = longint'(freq) * pos;
		quad = (angle / 64'd3373259426) & 3;
		z = longint'(angle % 64'd3373259426);
		x = 64'd652032874;
		y = 0;
		for (int i = 0; i < rope_pkg::ANGLE_ITERATIONS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_tab[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_tab[i];
			end
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		r1 = round_q(round_q(a * c - b * s, 30) * scale, 16);
		r2 = round_q(round_q(b * c + a * s, 30) * scale, 16);
		r.first = 32'(clip(r1, hit));
		r.second = 32'(clip(r2, hit));
		r.sat = hit;
		pending.push_back(r);
	endfunction

	function void check(logic [31:0] fr, logic [31:0] sr, logic last, logic sat);
		rotated_pair_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h %h", $time, fr, sr);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (fr !== e.first) begin
			$display("%0t: first_result expected %h actual %h", $time, e.first, fr);
			errors++;
		end
		if (sr !== e.second) begin
			$display("%0t: second_result expected %h actual %h", $time, e.second, sr);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: result_last expected %b actual %b", $time, e.last, last);
			errors++;
		end
		if (sat !== e.sat) begin
			$display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
			errors++;
		end
	endfunction
endclass

module rotary_embedding_half_split_logn_top_tb;
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_ROTATE    = 2'd1;
	localparam logic [1:0] REG_SPARE_A   = 2'd2;
	localparam logic [1:0] REG_SPARE_B   = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [15:0]        sequence_position = '0;
	logic [15:0]        step_base = '0;
	logic [15:0]        extra_offset = '0;
	logic [31:0]        inverse_frequency = '0;
	logic signed [31:0] first_value = '0;
	logic signed [31:0] second_value = '0;
	logic               last_pair = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [31:0] first_result;
	logic signed [31:0] second_result;
	logic               result_last;
	logic               saturated;

	rotary_scoreboard pairs = new();
	int               idle_pct = 0;
	int               stall_pct = 0;
	int               hold_left = 0;

	rotary_embedding_half_split_logn_top DUT (.*);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall = 1'b1;
			hold_left--;
		end else
			result_stall = ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			pairs.check(first_result, second_result, result_last, saturated);

	task automatic send(logic [15:0] seq, logic [15:0] step, logic [15:0] off,
			logic [31:0] freq, logic [31:0] fv, logic [31:0] sv, logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		@(negedge clk);
		item_valid = 1'b1;
		sequence_position = seq;
		step_base = step;
		extra_offset = off;
		inverse_frequency = freq;
		first_value = fv;
		second_value = sv;
		last_pair = last;
		forever begin
			@(posedge clk);
			if (!item_stall)
				break;
		end
		pairs.note(seq, step, off, freq, fv, sv, last);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		while (pairs.pending.size() != 0)
			@(negedge clk);
		repeat (rope_pkg::STAGES + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_THRESHOLD)
			pairs.threshold = value;
		else if (idx == REG_ROTATE)
			pairs.rotate = value[0];
	endtask

	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0001_0000;
			3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int count, logic [15:0] thr);
		logic [15:0] seq, step, off;
		int          top;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 1)) begin
				top = (thr > 65400) ? 65535 : thr + 100;
				seq = 16'($urandom_range(0, top));
				step = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
				off = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
			end else begin
				seq = 16'($urandom);
				step = 16'($urandom);
				off = 16'($urandom);
			end
			send(seq, step, off, $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom,
				pick_data(), pick_data(), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [15:0] thr_list[7];
		logic        rot_list[7];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes of the position and value fields at the reset settings.
		send(16'd0, 16'd0, 16'd0, 32'd0, 32'h0001_0000, 32'h0000_0000, 1'b0);
		send(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send(16'hFFFF, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send(16'd1, 16'd1, 16'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send(16'd7, 16'd0, 16'd0, 32'd3373259426, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		send(16'd1, 16'd0, 16'd0, 32'h4000_0000, 32'h1234_5678, 32'hEDCB_A988, 1'b1);
		send(16'd3, 16'd2, 16'd1, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 1'b0);
		send(16'h5555, 16'hAAAA, 16'h00FF, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		send(16'hAAAA, 16'h5555, 16'hFF00, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		drain();
		// Threshold of one drives the scale to its ceiling for positions above it.
		write_reg(REG_THRESHOLD, 16'd1);
		send(16'd2, 16'd0, 16'd0, 32'h1000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		send(16'd1, 16'd0, 16'd0, 32'h1000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0001, 1'b0);
		drain();
		write_reg(REG_THRESHOLD, 16'hFFFF);
		send(16'hFFFF, 16'd0, 16'd0, 32'h0100_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
		send(16'hFFFF, 16'd1, 16'd0, 32'h0100_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
		drain();
		// Unused indexes must leave both registers alone.
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h0000);
		write_reg(REG_ROTATE, 16'd0);
		send(16'd9, 16'd9, 16'd9, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send(16'd0, 16'd0, 16'd0, 32'd0, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0);
		drain();
		write_reg(REG_ROTATE, 16'd1);
		write_reg(REG_THRESHOLD, 16'd0);

		// The output is held off for a long stretch so that the chain backs up.
		hold_left = 300;
		random_items(150, 16'd0);
		drain();

		thr_list = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65535)), 16'd100,
			16'($urandom_range(2, 2000)), 16'd0};
		rot_list = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
		for (int p = 0; p < 7; p++) begin
			write_reg(REG_THRESHOLD, thr_list[p]);
			write_reg(REG_ROTATE, {15'd0, rot_list[p]});
			for (int m = 0; m < 4; m++) begin
				case (m)
					0: begin idle_pct = 0; stall_pct = 0; end
					1: begin idle_pct = 49; stall_pct = 0; end
					2: begin idle_pct = 0; stall_pct = 49; end
					default: begin idle_pct = 14; stall_pct = 14; end
				endcase
				random_items(20, thr_list[p]);
			end
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		while (pairs.pending.size() != 0)
			@(posedge clk);
		repeat (rope_pkg::STAGES + 20) @(posedge clk);
		if (pairs.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/rope_pkg.sv
hdl/rope_cell.sv
hdl/rotary_embedding_half_split_logn_top.sv
hdl/rope_chk.sv
sim/rotary_embedding_half_split_logn_top_tb.sv
